[rtl/core/dfq_pkg.sv]
// dfq_pkg: shared types, codes and helpers for the deduplicating fifo queue
// depends on nothing; imported by every module of the block but dfq_ram
`default_nettype none

package dfq_pkg;

	// sizing
	localparam int QUEUE_DEPTH = 16;
	localparam int KEY_BITS    = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OP_W        = 2;
	localparam int STAT_W      = 2;

	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [KEY_BITS-1:0] key_t;

	// request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH        = 2'd0,
		OP_PUSH_UNIQUE = 2'd1,
		OP_REMOVE      = 2'd2,
		OP_POP         = 2'd3
	} dfq_op_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE    = 2'd0,
		STAT_PRESENT = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_ABSENT  = 2'd3
	} dfq_stat_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POP_RD,
		S_APPLY
	} dfq_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic pop_rd;
		logic apply;
	} dfq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} dfq_sts_t;

	// circular slot of the entry at an offset from the head
	function automatic ptr_t slot_of(ptr_t head, cnt_t offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(offset);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/dedup_fifo_queue.sv]
// dedup_fifo_queue: top level of the deduplicating fifo queue
// depends on dfq_pkg, dfq_ctrl, dfq_dp (and dfq_ram below it)
//
// An order-keeping queue of up to 16 keys held in a small ram with registered
// read. One request is worked at a time and gives exactly one result. A push
// goes from the accepting idle state to the apply state, which writes the
// output register; a pop first passes the ram read state. A push-if-absent or
// a keyed removal walks every held entry, one ram read per cycle with the
// compare in the cycle after each read, before it reaches the apply state;
// the removal compacts the survivors in the same walk. A new request is
// accepted in the cycle after the previous result is written to the output
// register, even while that result is still stalled downstream. A finished
// request whose result finds the output register still stalled waits until
// it frees. The store needs no clearing after reset: only values read from
// held entries are used.
`default_nettype none

module dedup_fifo_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [dfq_pkg::OP_W-1:0]     op,
	input  wire logic [dfq_pkg::KEY_BITS-1:0] key,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [dfq_pkg::STAT_W-1:0]        status,
	output logic [dfq_pkg::KEY_BITS-1:0]      front_value,
	output logic [dfq_pkg::CNT_W-1:0]         removed_count,
	output logic [dfq_pkg::CNT_W-1:0]         occupancy
);
	import dfq_pkg::*;

	dfq_cmd_t cmd;
	dfq_sts_t sts;

	dfq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (op),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	dfq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.key          (key),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.front_value  (front_value),
		.removed_count(removed_count),
		.occupancy    (occupancy)
	);

endmodule

`default_nettype wire

[rtl/core/dfq_ram.sv]
// dfq_ram: generic one-write one-read ram with registered read data
// depends on nothing
`default_nettype none

module dfq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/dfq_ctrl.sv]
// dfq_ctrl: request sequencer of the deduplicating fifo queue
// depends on dfq_pkg
`default_nettype none

module dfq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [dfq_pkg::OP_W-1:0] op,
	output logic                   in_stall,
	input  wire dfq_pkg::dfq_sts_t sts,
	output dfq_pkg::dfq_cmd_t      cmd
);
	import dfq_pkg::*;

	dfq_state_t state_q;
	dfq_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (dfq_op_t'(op))
						OP_PUSH:        state_nxt = S_APPLY;
						OP_PUSH_UNIQUE: state_nxt = S_SCAN;
						OP_REMOVE:      state_nxt = S_SCAN;
						OP_POP:         state_nxt = S_POP_RD;
						default:        state_nxt = S_APPLY;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_APPLY;
				end
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				state_nxt  = S_APPLY;
			end
			S_APPLY: begin
				// wait for room in the result register
				if (sts.out_free) begin
					cmd.apply = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/dfq_dp.sv]
// dfq_dp: datapath of the deduplicating fifo queue: pointers, scan, result register
// depends on dfq_pkg and dfq_ram
`default_nettype none

module dfq_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [dfq_pkg::OP_W-1:0]     op,
	input  wire logic [dfq_pkg::KEY_BITS-1:0] key,
	input  wire dfq_pkg::dfq_cmd_t            cmd,
	output dfq_pkg::dfq_sts_t                 sts,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [dfq_pkg::STAT_W-1:0]        status,
	output logic [dfq_pkg::KEY_BITS-1:0]      front_value,
	output logic [dfq_pkg::CNT_W-1:0]         removed_count,
	output logic [dfq_pkg::CNT_W-1:0]         occupancy
);
	import dfq_pkg::*;

	// request and queue state
	dfq_op_t op_q;
	key_t    key_q;
	ptr_t    head_q;
	cnt_t    count_q;

	// scan state
	cnt_t rd_q;
	cnt_t wr_q;
	cnt_t removed_q;
	logic found_q;
	logic valid_s1;

	// result register
	logic      out_valid_q;
	dfq_stat_t status_q;
	key_t      front_q;
	cnt_t      removed_out_q;
	cnt_t      occ_q;

	// ram ports
	logic we;
	ptr_t waddr;
	key_t wdata;
	logic re;
	ptr_t raddr;
	key_t rdata;

	logic      rd_issue;
	logic      hit;
	logic      scan_wr;
	logic      full;
	logic      push_ok;
	dfq_stat_t res_status;
	key_t      res_front;
	cnt_t      res_removed;
	cnt_t      new_count;
	ptr_t      new_head;

	dfq_ram #(
		.WIDTH(KEY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// scan: issue one read a cycle, compare it in the cycle after
	assign rd_issue = cmd.scan && (rd_q != count_q);
	assign hit      = valid_s1 && (rdata == key_q);
	assign scan_wr  = cmd.scan && valid_s1 && !hit && (op_q == OP_REMOVE);

	// append condition at the end of a push
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push_ok = cmd.apply && !full
		&& ((op_q == OP_PUSH) || ((op_q == OP_PUSH_UNIQUE) && !found_q));

	// ram port muxing; compaction writes trail the reads
	assign re    = rd_issue || cmd.pop_rd;
	assign raddr = cmd.pop_rd ? head_q : slot_of(head_q, rd_q);
	assign we    = scan_wr || push_ok;
	assign waddr = scan_wr ? slot_of(head_q, wr_q) : slot_of(head_q, count_q);
	assign wdata = scan_wr ? rdata : key_q;

	assign sts.scan_done = (rd_q == count_q) && !valid_s1;
	assign sts.out_free  = !out_valid_q || !out_stall;

	// result of the finished request
	always_comb begin
		res_status  = STAT_DONE;
		res_front   = '0;
		res_removed = '0;
		new_count   = count_q;
		new_head    = head_q;
		unique case (op_q)
			OP_PUSH: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					new_count = count_q + 1'b1;
				end
			end
			OP_PUSH_UNIQUE: begin
				if (found_q) begin
					res_status = STAT_PRESENT;
				end else if (full) begin
					res_status = STAT_FULL;
				end else begin
					new_count = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				res_removed = removed_q;
				new_count   = wr_q;
				if (removed_q == '0) begin
					res_status = STAT_ABSENT;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					res_status = STAT_ABSENT;
				end else begin
					res_front = rdata;
					new_count = count_q - 1'b1;
					new_head  = slot_of(head_q, CNT_W'(1));
				end
			end
			default: res_status = STAT_DONE;
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= dfq_op_t'(op);
			key_q <= key;
		end
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q      <= '0;
			wr_q      <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= rd_issue;
			if (cmd.load) begin
				rd_q      <= '0;
				wr_q      <= '0;
				removed_q <= '0;
				found_q   <= 1'b0;
			end else begin
				if (rd_issue) begin
					rd_q <= rd_q + 1'b1;
				end
				if (cmd.scan && hit) begin
					found_q   <= 1'b1;
					removed_q <= removed_q + 1'b1;
				end
				if (scan_wr) begin
					wr_q <= wr_q + 1'b1;
				end
			end
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.apply) begin
			head_q  <= new_head;
			count_q <= new_count;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_q      <= res_status;
			front_q       <= res_front;
			removed_out_q <= res_removed;
			occ_q         <= new_count;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign front_value   = front_q;
	assign removed_count = removed_out_q;
	assign occupancy     = occ_q;

endmodule

`default_nettype wire

[rtl/core/dfq_checker.sv]
// dfq_checker: port-level checks of the deduplicating fifo queue, bound to the top
// depends on dfq_pkg
`default_nettype none

module dfq_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic [dfq_pkg::OP_W-1:0]     op,
	input wire logic [dfq_pkg::KEY_BITS-1:0] key,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [dfq_pkg::STAT_W-1:0]   status,
	input wire logic [dfq_pkg::KEY_BITS-1:0] front_value,
	input wire logic [dfq_pkg::CNT_W-1:0]    removed_count,
	input wire logic [dfq_pkg::CNT_W-1:0]    occupancy
);
	import dfq_pkg::*;

	// a stalled request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(op) && $stable(key))
		else $error("stalled request changed");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(front_value) && $stable(removed_count) && $stable(occupancy))
		else $error("stalled result changed");

	// occupancy never exceeds the depth
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy beyond depth");

	// a popped value only comes with a done status
	a_front_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (front_value != '0) |-> status == STAT_DONE)
		else $error("front value on a failed request");

	// removals only reported as done, and never more than were held
	a_removed_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (removed_count != '0) |-> status == STAT_DONE
			&& (CNT_W+1)'(removed_count) + (CNT_W+1)'(occupancy)
				<= (CNT_W+1)'(QUEUE_DEPTH))
		else $error("removal count inconsistent");

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (.*);

`default_nettype wire

[sim/tb.sv]
// tb: self-checking testbench for the deduplicating fifo queue (dedup_fifo_queue)
// depends on dfq_pkg and the rtl under rtl/core; holds its own model of the queue
// directed corner requests first, then randomized traffic mixes with random gaps and stalls

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfq_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 4;
	localparam int RANDOM_REQUESTS = 1700;
	localparam int IDLE_LIMIT      = 3000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int POOL_SIZE       = 8;
	localparam int PRINT_LIMIT     = 30;

	// traffic mixes for the random part
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_BALANCED,
		MIX_DUPES
	} traffic_mix_t;

	typedef struct {
		dfq_stat_t status;
		key_t      front;
		cnt_t      removed;
		cnt_t      held;
	} queue_result_t;

	// model of the queue and the results it still owes
	class queue_scoreboard;
		key_t          store[QUEUE_DEPTH];
		int            head;
		int            held;
		int            errors;
		queue_result_t pending_results[$];

		function new();
			head   = 0;
			held   = 0;
			errors = 0;
		endfunction

		function int slot_at(int offset);
			return (head + offset) % QUEUE_DEPTH;
		endfunction

		function bit holds_key(key_t k);
			for (int i = 0; i < held; i++) begin
				if (store[slot_at(i)] == k) return 1'b1;
			end
			return 1'b0;
		endfunction

		function dfq_stat_t append_key(key_t k);
			if (held >= QUEUE_DEPTH) return STAT_FULL;
			store[slot_at(held)] = k;
			held++;
			return STAT_DONE;
		endfunction

		// work out the result of an accepted request and queue it
		function void note_request(dfq_op_t code, key_t k);
			queue_result_t r;
			int kept;
			int dropped;
			r.status  = STAT_DONE;
			r.front   = '0;
			r.removed = '0;
			case (code)
				OP_PUSH: begin
					r.status = append_key(k);
				end
				OP_PUSH_UNIQUE: begin
					// presence wins over fullness
					r.status = holds_key(k) ? STAT_PRESENT : append_key(k);
				end
				OP_REMOVE: begin
					// pack survivors in order from the head
					kept    = 0;
					dropped = 0;
					for (int i = 0; i < held; i++) begin
						if (store[slot_at(i)] == k) begin
							dropped++;
						end else begin
							store[slot_at(kept)] = store[slot_at(i)];
							kept++;
						end
					end
					held      = kept;
					r.removed = cnt_t'(dropped);
					r.status  = (dropped == 0) ? STAT_ABSENT : STAT_DONE;
				end
				default: begin
					if (held == 0) begin
						r.status = STAT_ABSENT;
					end else begin
						r.front = store[head];
						head    = slot_at(1);
						held--;
					end
				end
			endcase
			r.held = cnt_t'(held);
			pending_results.push_back(r);
		endfunction

		task report_mismatch(string msg);
			if (errors < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// compare one accepted result with the oldest expectation
		task check_result(logic [STAT_W-1:0] st, logic [KEY_BITS-1:0] fv,
				logic [CNT_W-1:0] rc, logic [CNT_W-1:0] occ);
			queue_result_t e;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d front=%h removed=%0d occupancy=%0d",
					st, fv, rc, occ));
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.status || fv !== e.front || rc !== e.removed || occ !== e.held) begin
				report_mismatch($sformatf(
					"got status=%0d front=%h removed=%0d occupancy=%0d, want %0d %h %0d %0d",
					st, fv, rc, occ, e.status, e.front, e.removed, e.held));
			end
		endtask

		task check_leftovers();
			if (pending_results.size() != 0) begin
				report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
			end
		endtask
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                out_stall = 1'b0;
	logic [OP_W-1:0]     op        = '0;
	key_t                key       = '0;
	logic                in_stall;
	logic                out_valid;
	logic [STAT_W-1:0]   status;
	logic [KEY_BITS-1:0] front_value;
	logic [CNT_W-1:0]    removed_count;
	logic [CNT_W-1:0]    occupancy;

	queue_scoreboard sb;
	bit              calm;
	int              taken       = 0;
	int              idle_cycles = 0;
	int              stall_left  = 0;

	always #(HALF_PERIOD) clk = ~clk;

	dedup_fifo_queue DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.key          (key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.front_value  (front_value),
		.removed_count(removed_count),
		.occupancy    (occupancy)
	);

	// alternate calm stretches (no gaps, no stalls) with noisy ones
	always begin
		calm = ($urandom_range(0, 3) == 0);
		repeat ($urandom_range(100, 400)) @(posedge clk);
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic dfq_op_t pick_op(traffic_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 50) return OP_PUSH;
				if (r < 80) return OP_PUSH_UNIQUE;
				if (r < 90) return OP_REMOVE;
				return OP_POP;
			end
			MIX_DRAIN: begin
				if (r < 15) return OP_PUSH;
				if (r < 25) return OP_PUSH_UNIQUE;
				if (r < 55) return OP_REMOVE;
				return OP_POP;
			end
			MIX_DUPES: begin
				if (r < 30) return OP_PUSH;
				if (r < 70) return OP_PUSH_UNIQUE;
				if (r < 90) return OP_REMOVE;
				return OP_POP;
			end
			default: return dfq_op_t'(r % 4);
		endcase
	endfunction

	function automatic key_t pool_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return '0;
		if (r < 4) return '1;
		return key_t'($urandom);
	endfunction

	// result side stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && $urandom_range(0, 9) < 3) begin
			out_stall <= 1'b1;
			stall_left = pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// handshake monitor: results checked before the new request is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(status, front_value, removed_count, occupancy);
			if (in_valid && !in_stall) begin
				sb.note_request(dfq_op_t'(op), key);
				taken++;
			end
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	// watchdog on cycles with no handshake
	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// drive one request and hold it until it is taken; entered at a falling edge
	task automatic send_request(dfq_op_t code, key_t k);
		int gap;
		int seen;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		key      <= k;
		seen = taken;
		do @(negedge clk); while (taken == seen);
	endtask

	initial begin
		traffic_mix_t mix;
		key_t         pool[POOL_SIZE];
		key_t         k;
		int           pool_used;
		int           seg_len;
		int           sent;

		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty queue corners
		send_request(OP_POP, 16'h0000);
		send_request(OP_REMOVE, 16'hFFFF);
		// duplicates and keyed removal
		send_request(OP_PUSH, 16'h0000);
		send_request(OP_PUSH, 16'hFFFF);
		send_request(OP_PUSH, 16'hFFFF);
		send_request(OP_PUSH_UNIQUE, 16'hFFFF);
		send_request(OP_PUSH_UNIQUE, 16'h5A5A);
		send_request(OP_REMOVE, 16'hA5A5);
		send_request(OP_REMOVE, 16'hFFFF);
		// fill up
		for (int i = 0; i < QUEUE_DEPTH - 2; i++) begin
			send_request(OP_PUSH, (i % 2 == 1) ? 16'hA5A5 : key_t'($urandom));
		end
		// full queue corners
		send_request(OP_PUSH, 16'h7777);
		send_request(OP_PUSH_UNIQUE, 16'h5A5A);
		send_request(OP_PUSH_UNIQUE, 16'h8001);
		send_request(OP_REMOVE, 16'hA5A5);
		send_request(OP_POP, 16'hFFFF);

		// random segments, each with its own mix and key pool
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			mix       = traffic_mix_t'($urandom_range(0, 3));
			seg_len   = $urandom_range(20, 80);
			pool_used = (mix == MIX_DUPES) ? 3 : POOL_SIZE;
			for (int i = 0; i < POOL_SIZE; i++) pool[i] = pool_key();
			for (int n = 0; n < seg_len && sent < RANDOM_REQUESTS; n++) begin
				k = ($urandom_range(0, 3) == 0) ? key_t'($urandom) : pool[$urandom_range(0, pool_used - 1)];
				send_request(pick_op(mix), k);
				sent++;
			end
		end
		in_valid <= 1'b0;

		// let outstanding results drain, then watch for strays
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		sb.check_leftovers();
		if (sb.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
